// ===== rtl/brn_pkg.sv =====
package brn_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int WORD_BITS  = 16;
  localparam int WPR_MAX    = (MAX_WIDTH + 15) / 16;
  localparam int DEPTH      = WPR_MAX * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int SIZE_W     = 7;
  localparam int CNT_W      = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_READ = 1'b1
  } mode_t;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic signed [15:0] cs;
    logic signed [15:0] sn;
  } trig_t;

  typedef struct packed {
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    logic [2:0]        wpr;
    logic [5:0]        xc;
    logic [5:0]        yc;
  } geom_t;

  typedef struct packed {
    logic       vld;
    logic [3:0] n;
    logic [1:0] colw;
    logic [7:0] row;
    logic [1:0] sel;
  } pix_req_t;

  typedef struct packed {
    logic       vld;
    logic       hit;
    logic [3:0] n;
    logic [3:0] bsel;
  } pix_tag_t;

  // Q2.14 cos/sin of -90, -112.5, -135, -157.5 degrees
  function automatic trig_t angle_trig(input logic [1:0] sel);
    trig_t t;
    case (sel)
      2'd0: begin
        t.cs = 16'sd0;
        t.sn = -16'sd16384;
      end
      2'd1: begin
        t.cs = -16'sd6270;
        t.sn = -16'sd15137;
      end
      2'd2: begin
        t.cs = -16'sd11585;
        t.sn = -16'sd11585;
      end
      default: begin
        t.cs = -16'sd15137;
        t.sn = -16'sd6270;
      end
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/brn_bitmap_ram.sv =====
module brn_bitmap_ram #(
  parameter int DATA_W = 16,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/brn_pixel_map.sv =====
module brn_pixel_map (
  input  logic                     clk,
  input  logic                     rst_n,
  input  brn_pkg::pix_req_t        req,
  input  brn_pkg::geom_t           geom,
  output logic                     rd_en,
  output logic [brn_pkg::ADDR_W-1:0] rd_addr,
  output brn_pkg::pix_tag_t        tag
);

  brn_pkg::trig_t     trig;
  logic [5:0]         j;
  logic signed [7:0]  dj;
  logic signed [8:0]  dk;
  logic               ok;

  logic               a_vld_r;
  logic               a_ok_r;
  logic [3:0]         a_n_r;
  logic signed [23:0] a_cx_r;
  logic signed [23:0] a_sx_r;
  logic signed [24:0] a_sy_r;
  logic signed [24:0] a_cy_r;

  logic signed [27:0] x_q;
  logic signed [27:0] y_q;
  logic [13:0]        x_int;
  logic [13:0]        y_int;
  logic               x_ok;
  logic               y_ok;
  logic               hit;
  logic [9:0]         y_base;
  brn_pkg::pix_tag_t  tag_r;

  // stage A: centred coordinates and the four products
  always_comb begin
    trig = brn_pkg::angle_trig(req.sel);
    j    = {req.colw, req.n};
    dj   = $signed({2'b00, j}) - $signed({2'b00, geom.xc});
    dk   = $signed({1'b0, req.row}) - $signed({3'b000, geom.yc});
    ok   = ({1'b0, j} < geom.w) && (req.row < {1'b0, geom.h});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= req.vld;
    end
  end

  always_ff @(posedge clk) begin
    a_ok_r <= ok;
    a_n_r  <= req.n;
    a_cx_r <= dj * trig.cs;
    a_sx_r <= dj * trig.sn;
    a_sy_r <= dk * trig.sn;
    a_cy_r <= dk * trig.cs;
  end

  // stage B: add centre + 0.5, truncate toward zero, bound check, address
  always_comb begin
    x_q = 28'(a_cx_r) - 28'(a_sy_r) + $signed({8'd0, geom.xc, 14'h2000});
    y_q = 28'(a_sx_r) + 28'(a_cy_r) + $signed({8'd0, geom.yc, 14'h2000});
    x_int  = x_q[27] ? 14'd0 : x_q[27:14];
    y_int  = y_q[27] ? 14'd0 : y_q[27:14];
    x_ok   = (x_q >= -28'sd16383) && (x_int < {7'd0, geom.w});
    y_ok   = (y_q >= -28'sd16383) && (y_int < {7'd0, geom.h});
    hit    = a_ok_r && x_ok && y_ok;
    y_base = y_int[6:0] * geom.wpr;
    rd_en  = a_vld_r && hit;
    rd_addr = brn_pkg::ADDR_W'(y_base + {8'd0, x_int[5:4]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.vld <= 1'b0;
    end else begin
      tag_r.vld <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    tag_r.hit  <= hit;
    tag_r.n    <= a_n_r;
    tag_r.bsel <= x_int[3:0];
  end

  assign tag = tag_r;

endmodule

// ===== rtl/bitmap_rotate_nearest.sv =====
// Load beat: written to the bitmap RAM at the accepting edge.
// Read beat: one pixel per cycle over 16 pixels, set by the single RAM read port,
// through a three-stage map/read/collect pipeline, then a result handoff; no new
// beat is taken until the result is loaded into the result register.
// Synchronous active-low reset clears control and sets both sizes to 64;
// bitmap contents are undefined until written.
module bitmap_rotate_nearest (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [7:0]  in_word_index,
  input  logic [15:0] in_load_data,
  input  logic [1:0]  in_angle_select,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_index,
  output logic [15:0] out_word,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [brn_pkg::CNT_W-1:0] RUN_LAST = brn_pkg::CNT_W'(brn_pkg::WORD_BITS + 1);

  brn_pkg::state_t   state_r, state_nxt;
  logic [brn_pkg::CNT_W-1:0] cnt_r;
  logic [brn_pkg::SIZE_W-1:0] image_width_r, image_height_r;
  logic [7:0]        idx_r, row_r;
  logic [1:0]        colw_r, sel_r;
  logic [15:0]       word_r;
  logic              out_valid_r;
  logic [7:0]        out_index_r;
  logic [15:0]       out_word_r;

  logic              accept, wr_en, issue, out_load, cfg_wr;
  brn_pkg::geom_t    geom;
  brn_pkg::pix_req_t req;
  brn_pkg::pix_tag_t tag;
  logic              rd_en;
  logic [brn_pkg::ADDR_W-1:0] rd_addr;
  logic [15:0]       rd_data;

  logic [7:0]        row_nxt;
  logic [1:0]        colw_nxt;
  logic [16:0]       div3_prod;
  logic [7:0]        row3;
  logic [9:0]        row3x3;
  logic [7:0]        rem3;

  // effective geometry
  always_comb begin
    if (image_width_r == '0) begin
      geom.w = brn_pkg::SIZE_W'(1);
    end else if (image_width_r > brn_pkg::SIZE_W'(brn_pkg::MAX_WIDTH)) begin
      geom.w = brn_pkg::SIZE_W'(brn_pkg::MAX_WIDTH);
    end else begin
      geom.w = image_width_r;
    end
    if (image_height_r == '0) begin
      geom.h = brn_pkg::SIZE_W'(1);
    end else if (image_height_r > brn_pkg::SIZE_W'(brn_pkg::MAX_HEIGHT)) begin
      geom.h = brn_pkg::SIZE_W'(brn_pkg::MAX_HEIGHT);
    end else begin
      geom.h = image_height_r;
    end
    geom.wpr = 3'((geom.w + 7'd15) >> 4);
    geom.xc  = geom.w[6:1];
    geom.yc  = geom.h[6:1];
  end

  // row and column word of the requested index
  always_comb begin
    div3_prod = in_word_index * 9'd171;
    row3      = div3_prod[16:9];
    row3x3    = {2'b00, row3} + {1'b0, row3, 1'b0};
    rem3      = in_word_index - row3x3[7:0];
    case (geom.wpr)
      3'd1: begin
        row_nxt  = in_word_index;
        colw_nxt = 2'd0;
      end
      3'd2: begin
        row_nxt  = {1'b0, in_word_index[7:1]};
        colw_nxt = {1'b0, in_word_index[0]};
      end
      3'd3: begin
        row_nxt  = row3;
        colw_nxt = rem3[1:0];
      end
      default: begin
        row_nxt  = {2'b00, in_word_index[7:2]};
        colw_nxt = in_word_index[1:0];
      end
    endcase
  end

  // configuration
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= brn_pkg::SIZE_W'(brn_pkg::MAX_WIDTH);
      image_height_r <= brn_pkg::SIZE_W'(brn_pkg::MAX_HEIGHT);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        brn_pkg::REG_WIDTH:  image_width_r  <= pwdata[brn_pkg::SIZE_W-1:0];
        brn_pkg::REG_HEIGHT: image_height_r <= pwdata[brn_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      brn_pkg::REG_WIDTH:  prdata = {25'd0, image_width_r};
      brn_pkg::REG_HEIGHT: prdata = {25'd0, image_height_r};
      default:             prdata = '0;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      brn_pkg::ST_IDLE: begin
        if (in_valid && in_mode == brn_pkg::MODE_READ) begin
          state_nxt = brn_pkg::ST_RUN;
        end
      end
      brn_pkg::ST_RUN: begin
        if (cnt_r == RUN_LAST) begin
          state_nxt = brn_pkg::ST_DONE;
        end
      end
      brn_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = brn_pkg::ST_IDLE;
        end
      end
      default: state_nxt = brn_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      brn_pkg::ST_IDLE: in_ready = 1'b1;
      brn_pkg::ST_RUN:  issue    = !cnt_r[brn_pkg::CNT_W-1];
      brn_pkg::ST_DONE: out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  assign accept = in_valid && in_ready;
  assign wr_en  = accept && in_mode == brn_pkg::MODE_LOAD;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= brn_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        cnt_r <= '0;
      end else if (state_r == brn_pkg::ST_RUN) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_mode == brn_pkg::MODE_READ) begin
      idx_r  <= in_word_index;
      sel_r  <= in_angle_select;
      row_r  <= row_nxt;
      colw_r <= colw_nxt;
      word_r <= '0;
    end else if (tag.vld && tag.hit && rd_data[tag.bsel]) begin
      word_r[tag.n] <= 1'b1;
    end
  end

  assign req.vld  = issue;
  assign req.n    = cnt_r[3:0];
  assign req.colw = colw_r;
  assign req.row  = row_r;
  assign req.sel  = sel_r;

  brn_pixel_map u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .geom    (geom),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .tag     (tag)
  );

  brn_bitmap_ram #(
    .DATA_W (brn_pkg::WORD_BITS),
    .ADDR_W (brn_pkg::ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_word_index),
    .wr_data (in_load_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_index_r <= idx_r;
      out_word_r  <= word_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_index = out_index_r;
  assign out_word  = out_word_r;

`ifndef SYNTHESIS
  a_collect_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    tag.vld |-> state_r == brn_pkg::ST_RUN)
    else $error("pixel collected outside run");

  a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !wr_en)
    else $error("bitmap read and load in same cycle");

  a_read_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_mode == brn_pkg::MODE_READ |=> state_r == brn_pkg::ST_RUN)
    else $error("read beat did not start a run");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == brn_pkg::ST_DONE))
    else $error("result raised outside done");
`endif

endmodule
